[rtl/samtf_pkg.sv]
// Shared constants and types for the set-associative move-to-front slot table.
`timescale 1ns / 1ps
package samtf_pkg;

	localparam int WAYS     = 8;
	localparam int MAX_SETS = 256;
	localparam int ID_BITS  = 20;

	// fixed field widths of the channels and the config register
	localparam int ID_W  = 20;
	localparam int CFG_W = 9;

	localparam int WAYS_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int DIV_W  = $clog2(MAX_SETS + 1);

	// remainder unit: bits of the id consumed per cycle
	localparam int MOD_STEP  = 4;
	localparam int MOD_ITERS = (ID_BITS + MOD_STEP - 1) / MOD_STEP;
	localparam int PAD_W     = MOD_ITERS * MOD_STEP;
	localparam int CNT_W     = (MOD_ITERS > 1) ? $clog2(MOD_ITERS) : 1;

	localparam logic [CFG_W-1:0] NUM_SETS_RST = CFG_W'(256);

	localparam logic FUNC_CHECKOUT = 1'b0;
	localparam logic FUNC_RELEASE  = 1'b1;

	typedef struct packed {
		logic               vld;
		logic [ID_BITS-1:0] id;
	} slot_t;

	typedef slot_t [WAYS-1:0] row_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_UPDATE
	} state_t;

endpackage

[rtl/samtf_if.sv]
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface samtf_req_if;
	import samtf_pkg::*;

	logic            valid;
	logic            ready;
	logic            func;
	logic [ID_W-1:0] block_id;

	modport source (output valid, output func, output block_id, input ready);
	modport sink   (input valid, input func, input block_id, output ready);
endinterface

interface samtf_rsp_if;
	import samtf_pkg::*;

	logic            valid;
	logic            ready;
	logic            hit;
	logic            evict_valid;
	logic [ID_W-1:0] evicted_id;

	modport source (output valid, output hit, output evict_valid, output evicted_id,
		input ready);
	modport sink   (input valid, input hit, input evict_valid, input evicted_id,
		output ready);
endinterface

[rtl/set_assoc_move_to_front_slots_unit.sv]
// Set-associative slot table with checkout/release and move-to-front insertion.
`timescale 1ns / 1ps
// One request at a time. After the transfer the set index (block_id mod num_sets)
// is formed by a remainder unit that consumes 4 id bits per cycle; then the set's
// row is read from the table RAM, and in the update state all ways are compared in
// parallel, the row is shifted on a release and written back while the response
// register is loaded. The next request is accepted only after that write, which
// waits while a previous response is still held. The response register lets a
// new request start while the last response waits. Each set row has a valid flop
// cleared by reset, so the table is empty right after reset with no clearing
// sweep. num_sets of 0 acts as 1 and values above 256 act as 256; change it only
// while the unit is idle.
module set_assoc_move_to_front_slots_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	samtf_req_if.sink                 req,
	samtf_rsp_if.source               rsp,
	input  logic                      cfg_we,
	input  logic [samtf_pkg::CFG_W-1:0] cfg_data
);
	import samtf_pkg::*;

	state_t              state_q, state_nx;
	logic [CFG_W-1:0]    num_sets_q;
	logic [DIV_W-1:0]    div_eff, div_q;
	logic [DIV_W-1:0]    rem_q, rem_nx;
	logic [DIV_W:0]      wide;
	logic [PAD_W-1:0]    idsh_q;
	logic [CNT_W-1:0]    mcnt_q;
	logic [ID_BITS-1:0]  id_q;
	logic                func_q;
	logic [SET_W-1:0]    set_q;

	row_t                table_q [MAX_SETS];
	logic [MAX_SETS-1:0] row_live_q;
	row_t                rd_row_q;
	logic                rd_live_q;
	row_t                cur_row, wr_row;

	logic                found, full, hit_c, evict_c;
	logic [WAYS_W-1:0]   hole;
	logic [ID_W-1:0]     ev_id_c;

	logic                out_vld_q, out_hit_q, out_ev_q;
	logic [ID_W-1:0]     out_ev_id_q;

	logic                accept, mod_last, out_free;
	logic                mod_run, rd_en, mem_we;

	assign accept   = req.valid && req.ready;
	assign mod_last = (mcnt_q == CNT_W'(MOD_ITERS - 1));
	assign out_free = !out_vld_q || rsp.ready;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_sets_q <= NUM_SETS_RST;
		end else if (cfg_we) begin
			num_sets_q <= cfg_data;
		end
	end

	always_comb begin
		if (num_sets_q == '0) begin
			div_eff = DIV_W'(1);
		end else if (32'(num_sets_q) > MAX_SETS) begin
			div_eff = DIV_W'(MAX_SETS);
		end else begin
			div_eff = DIV_W'(num_sets_q);
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:   if (req.valid) state_nx = ST_MOD;
			ST_MOD:    if (mod_last) state_nx = ST_READ;
			ST_READ:   state_nx = ST_UPDATE;
			ST_UPDATE: if (out_free) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		mod_run   = 1'b0;
		rd_en     = 1'b0;
		mem_we    = 1'b0;
		case (state_q)
			ST_IDLE:   req.ready = 1'b1;
			ST_MOD:    mod_run = 1'b1;
			ST_READ:   rd_en = 1'b1;
			ST_UPDATE: mem_we = out_free;
			default:   req.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// restoring remainder, MOD_STEP bits per cycle, msb first
	always_comb begin
		rem_nx = rem_q;
		wide   = '0;
		for (int k = 0; k < MOD_STEP; k++) begin
			wide = {rem_nx, idsh_q[PAD_W-1-k]};
			if (wide >= {1'b0, div_q}) begin
				wide = wide - {1'b0, div_q};
			end
			rem_nx = wide[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (accept) begin
			mcnt_q <= '0;
		end else if (mod_run) begin
			mcnt_q <= mcnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			id_q   <= req.block_id[ID_BITS-1:0];
			idsh_q <= PAD_W'(req.block_id[ID_BITS-1:0]);
			div_q  <= div_eff;
			rem_q  <= '0;
		end else if (mod_run) begin
			idsh_q <= idsh_q << MOD_STEP;
			rem_q  <= rem_nx;
			if (mod_last) begin
				set_q <= rem_nx[SET_W-1:0];
			end
		end
	end

	// table RAM, one row per set
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_q[set_q] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= table_q[set_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_live_q <= '0;
			rd_live_q  <= 1'b0;
		end else begin
			if (mem_we) begin
				row_live_q[set_q] <= 1'b1;
			end
			if (rd_en) begin
				rd_live_q <= row_live_q[set_q];
			end
		end
	end

	// a row never written since reset reads as all empty
	assign cur_row = rd_live_q ? rd_row_q : '0;

	always_comb begin
		wr_row  = cur_row;
		found   = 1'b0;
		full    = 1'b0;
		hole    = WAYS_W'(WAYS - 1);
		if (func_q == FUNC_CHECKOUT) begin
			for (int i = 0; i < WAYS; i++) begin
				if (!found && cur_row[i].vld && cur_row[i].id == id_q) begin
					found     = 1'b1;
					wr_row[i] = '0;
				end
			end
		end else begin
			for (int i = 0; i < WAYS; i++) begin
				if (!found && !cur_row[i].vld) begin
					found = 1'b1;
					hole  = WAYS_W'(i);
				end
			end
			full = !found;
			for (int i = 1; i < WAYS; i++) begin
				if (WAYS_W'(i) <= hole) begin
					wr_row[i] = cur_row[i-1];
				end
			end
			wr_row[0] = '{vld: 1'b1, id: id_q};
		end
		hit_c   = (func_q == FUNC_CHECKOUT) && found;
		evict_c = (func_q == FUNC_RELEASE) && full;
		ev_id_c = evict_c ? ID_W'(cur_row[WAYS-1].id) : '0;
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (mem_we) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			out_hit_q   <= hit_c;
			out_ev_q    <= evict_c;
			out_ev_id_q <= ev_id_c;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.evict_valid = out_ev_q;
	assign rsp.evicted_id  = out_ev_id_q;

	// checks
	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> rem_q < div_q)
		else $error("set index not below set count");

	a_release_front: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && func_q == FUNC_RELEASE |-> wr_row[0].vld && wr_row[0].id == id_q)
		else $error("release did not place id at front");

	a_rsp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.hit && rsp.evict_valid))
		else $error("hit and evict both set");

	a_evict_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.evict_valid |-> rsp.evicted_id == '0)
		else $error("evicted id nonzero without eviction");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !rsp.ready |=> out_vld_q && $stable(out_ev_id_q))
		else $error("held response overwritten");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the set-associative move-to-front slot table.
`timescale 1ns / 1ps
module testbench;
	import samtf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TABLE_DEPTH = MAX_SETS * WAYS;
	localparam int ID_MAX      = (1 << ID_W) - 1;

	typedef struct packed {
		logic            hit;
		logic            evict_valid;
		logic [ID_W-1:0] evicted_id;
	} outcome_t;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             cfg_we   = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	samtf_req_if req();
	samtf_rsp_if rsp();

	set_assoc_move_to_front_slots_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// shadow copy of the slot table and the set count register
	logic             slot_vld [TABLE_DEPTH];
	logic [ID_W-1:0]  slot_tag [TABLE_DEPTH];
	logic [CFG_W-1:0] sets_reg;
	outcome_t         outcome_q [$];
	logic [ID_W-1:0]  held_ids [$];   // recently released ids, targets for checkouts

	int send_idle_pct = 29;
	int recv_idle_pct = 68;
	int cycles        = 0;
	int mismatches    = 0;
	int results_seen  = 0;
	int hits_seen     = 0;
	int evicts_seen   = 0;
	int releases_sent = 0;
	int checkouts_sent = 0;

	function automatic int sets_in_use();
		int n = sets_reg;
		if (n == 0) n = 1;
		if (n > MAX_SETS) n = MAX_SETS;
		return n;
	endfunction

	function automatic void predict_request(logic f, logic [ID_W-1:0] id);
		int base;
		int hole;
		outcome_t o;
		logic [ID_W-1:0] key;
		key  = id & ID_W'((1 << ID_BITS) - 1);
		base = int'(key % sets_in_use()) * WAYS;
		o    = '0;
		if (f == FUNC_CHECKOUT) begin
			// lowest matching slot only
			for (int i = 0; i < WAYS; i++) begin
				if (slot_vld[base+i] && slot_tag[base+i] == key) begin
					slot_vld[base+i] = 1'b0;
					slot_tag[base+i] = '0;
					o.hit = 1'b1;
					break;
				end
			end
		end else begin
			hole = -1;
			for (int i = 0; i < WAYS; i++) begin
				if (!slot_vld[base+i]) begin
					hole = i;
					break;
				end
			end
			if (hole < 0) begin
				o.evict_valid = 1'b1;
				o.evicted_id  = slot_tag[base+WAYS-1];
				hole = WAYS - 1;
			end
			for (int i = hole; i > 0; i--) begin
				slot_vld[base+i] = slot_vld[base+i-1];
				slot_tag[base+i] = slot_tag[base+i-1];
			end
			slot_vld[base] = 1'b1;
			slot_tag[base] = key;
		end
		outcome_q.push_back(o);
	endfunction

	task automatic send_request(logic f, logic [ID_W-1:0] id);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid    <= 1'b1;
		req.func     <= f;
		req.block_id <= id;
		do @(posedge clk); while (!req.ready);
		predict_request(f, id);
		if (f == FUNC_RELEASE) begin
			releases_sent++;
			held_ids.push_back(id);
			if (held_ids.size() > 48) void'(held_ids.pop_front());
		end else begin
			checkouts_sent++;
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req.valid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_sets(logic [CFG_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we   <= 1'b0;
		sets_reg = v;
	endtask

	// at the reset set count of 256
	task automatic test_field_extremes();
		send_request(FUNC_RELEASE, '0);
		send_request(FUNC_RELEASE, ID_W'(ID_MAX));
		send_request(FUNC_CHECKOUT, ID_W'(ID_MAX));
		send_request(FUNC_CHECKOUT, '0);
		send_request(FUNC_CHECKOUT, '0);
	endtask

	// fill set 5, evict, duplicate, checkout, then insert into a hole
	task automatic test_full_set();
		for (int k = 0; k < WAYS + 1; k++)
			send_request(FUNC_RELEASE, ID_W'(5 + 256 * k));
		send_request(FUNC_RELEASE, ID_W'(5 + 256 * WAYS));
		send_request(FUNC_CHECKOUT, ID_W'(5 + 256 * WAYS));
		send_request(FUNC_CHECKOUT, ID_W'(5 + 256 * 4));
		send_request(FUNC_RELEASE, ID_W'(5 + 256 * 20));
	endtask

	// entries stay put when the set count changes under them
	task automatic test_set_count_change();
		write_sets(CFG_W'(1));
		send_request(FUNC_CHECKOUT, ID_W'(5 + 256 * 3));
		send_request(FUNC_RELEASE, ID_W'(7));
		write_sets('0);
		send_request(FUNC_RELEASE, ID_W'(9));
		send_request(FUNC_CHECKOUT, ID_W'(7));
		write_sets(CFG_W'(511));
		send_request(FUNC_CHECKOUT, ID_W'(5 + 256 * 5));
	endtask

	task automatic test_random(int n, logic [CFG_W-1:0] sets, int sidle, int ridle);
		int eff;
		int set_idx;
		int span;
		int pick;
		logic f;
		logic [ID_W-1:0] id;
		write_sets(sets);
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		eff = sets_in_use();
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				f  = logic'($urandom_range(1));
				id = ID_W'($urandom_range(ID_MAX));
			end else if (pick < 45 && held_ids.size() > 0) begin
				f  = FUNC_CHECKOUT;
				id = held_ids[$urandom_range(held_ids.size() - 1)];
			end else begin
				// mostly a few hot sets so they fill and evict
				if ($urandom_range(3) == 0)
					set_idx = $urandom_range(eff - 1);
				else
					set_idx = $urandom_range(((eff < 4) ? eff : 4) - 1);
				span = (ID_MAX - set_idx) / eff;
				id   = ID_W'(set_idx + eff * int'($urandom_range(span)));
				f    = (pick < 80) ? FUNC_RELEASE : FUNC_CHECKOUT;
			end
			send_request(f, id);
		end
	endtask

	always @(negedge clk)
		rsp.ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_results
		outcome_t got;
		outcome_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.hit         = rsp.hit;
			got.evict_valid = rsp.evict_valid;
			got.evicted_id  = rsp.evicted_id;
			results_seen++;
			if (got.hit) hits_seen++;
			if (got.evict_valid) evicts_seen++;
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected transfer hit=%0b evict=%0b id=%05h", $realtime,
						got.hit, got.evict_valid, got.evicted_id);
			end else begin
				want = outcome_q.pop_front();
				if (got.hit !== want.hit || got.evict_valid !== want.evict_valid ||
					got.evicted_id !== want.evicted_id) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch exp hit=%0b evict=%0b id=%05h, got hit=%0b evict=%0b id=%05h",
							$realtime, want.hit, want.evict_valid, want.evicted_id,
							got.hit, got.evict_valid, got.evicted_id);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out with %0d results outstanding", outcome_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		req.valid    = 1'b0;
		req.func     = FUNC_CHECKOUT;
		req.block_id = '0;
		rsp.ready    = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			slot_vld[i] = 1'b0;
			slot_tag[i] = '0;
		end
		sets_reg = NUM_SETS_RST;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_field_extremes();
		test_full_set();
		test_set_count_change();
		test_random(170, CFG_W'(3), 29, 68);
		test_random(170, CFG_W'(256), 29, 68);
		test_random(170, CFG_W'(1), 68, 29);
		test_random(170, CFG_W'(97), 68, 29);
		test_random(150, CFG_W'(511), 0, 0);

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Covered %0d releases and %0d checkouts across set counts 0..511",
			releases_sent, checkouts_sent);
		$display("Checked %0d results: %0d hits, %0d evictions, %0d mismatches",
			results_seen, hits_seen, evicts_seen, mismatches);
		if (mismatches == 0 && outcome_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

[set_assoc_move_to_front_slots_unit.f]
rtl/samtf_pkg.sv
rtl/samtf_if.sv
rtl/set_assoc_move_to_front_slots_unit.sv
dv/testbench.sv
